>>> rtl/sampled_multichannel_pulse_counter_macros.svh
// Assertion helpers used by the pulse counter back end.
`ifndef SAMPLED_MULTICHANNEL_PULSE_COUNTER_MACROS_SVH
`define SAMPLED_MULTICHANNEL_PULSE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpc assertion failed");

// Next-cycle implication, disabled during reset.
`define SMPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpc assertion failed");

`endif

>>> rtl/smpc_pkg.sv
package smpc_pkg;

   typedef enum logic [1:0] {
      ITEM_TICK,
      ITEM_INIT,
      ITEM_DROP
   } item_kind_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_INIT = 1'b1;

   localparam logic EV_REQUEST = 1'b0;
   localparam logic EV_PUBLISH = 1'b1;

   localparam logic REG_SAMPLE_PERIOD = 1'b0;
   localparam logic REG_QUERY_PERIOD  = 1'b1;

   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd500;
   localparam logic [15:0] QUERY_PERIOD_RESET  = 16'd10000;

   localparam int RESULT_LIMIT = 8;
   localparam int PIN_COUNT    = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RCNT_W       = $clog2(RESULT_LIMIT);

   typedef struct packed {
      item_kind_type         kind;
      logic [PIN_COUNT-1:0]  pins;
      logic                  link_up;
      logic [1:0]            channel;
      logic [31:0]           value;
   } item_type;

   typedef struct packed {
      logic [15:0] sample_period;
      logic [15:0] query_period;
   } cfg_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

>>> rtl/sampled_multichannel_pulse_counter.sv
// Sampled multichannel pulse counter.
// Request channel (req_*): valid/stall. An item is a millisecond tick
// (opcode 0: all pin levels and link status) or an initial count for one
// channel (opcode 1). Result channel (rsp_*): valid/stall, one event per
// item moved: a request for a channel's initial count or a publish of its
// 32-bit count; rsp_last_of_run marks the final event of a tick.
// Configuration (csr_*): write-only sample and query periods, written while idle.
// With the back end idle, the first event of a tick reaches the result ports
// through the pop and state update, then the output register.
// A tick holds the back end until its events are out, one event per cycle
// through the single output register while rsp_stall is low; an initial
// count gives no result. Up to 8 events per tick.
// A two-entry queue sits between the front and back ends, so ticks are
// accepted while earlier events still drain.
// Reset: counts, levels, timers and flags clear, the first tick loads the pin
// levels without counting, and the periods return to 500 and 10000 ms.
// When rsp_stall is high the output holds and the queue fills; req_stall
// rises once both queue entries are taken.
module sampled_multichannel_pulse_counter #(
   parameter int CHANNELS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_opcode,
   input  logic [3:0]   req_pin_levels,
   input  logic         req_link_up,
   input  logic [1:0]   req_channel,
   input  logic [31:0]  req_initial_value,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_event_kind,
   output logic [1:0]   rsp_event_channel,
   output logic [31:0]  rsp_count_value,
   output logic         rsp_last_of_run,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);
   import smpc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // Decode register writes; unused fields hold.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SAMPLE_PERIOD: cfg_in.sample_period = csr_data;
            REG_QUERY_PERIOD:  cfg_in.query_period  = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= SAMPLE_PERIOD_RESET;
         cfg_ff.query_period  <= QUERY_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept, classify and queue items.
   smpc_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pin_levels    (req_pin_levels),
      .req_link_up       (req_link_up),
      .req_channel       (req_channel),
      .req_initial_value (req_initial_value),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // Back end: update channel state and emit events one per cycle while rsp_stall is low.
   smpc_back #(
      .CHANNELS(CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_channel (rsp_event_channel),
      .rsp_count_value   (rsp_count_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

>>> rtl/smpc_front.sv
module smpc_front #(
   parameter int CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [3:0]                 req_pin_levels,
   input  logic                       req_link_up,
   input  logic [1:0]                 req_channel,
   input  logic [31:0]                req_initial_value,
   output logic                       q_valid,
   output smpc_pkg::item_type         q_item,
   input  logic                       q_pop
);
   import smpc_pkg::*;

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   item_type            item_new;
   logic                push;

   // Classify: ticks, initial counts for a real channel, and the rest to drop.
   always_comb begin
      item_new.pins    = req_pin_levels;
      item_new.link_up = req_link_up;
      item_new.channel = req_channel;
      item_new.value   = req_initial_value;
      priority if (req_opcode == OP_TICK) begin
         item_new.kind = ITEM_TICK;
      end else if ({30'd0, req_channel} < 32'(CHANNELS)) begin
         item_new.kind = ITEM_INIT;
      end else begin
         item_new.kind = ITEM_DROP;
      end
   end

   assign req_stall = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QFILL_W'(push) - QFILL_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> rtl/smpc_back.sv
`include "sampled_multichannel_pulse_counter_macros.svh"

module smpc_back #(
   parameter int CHANNELS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smpc_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  smpc_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_event_kind,
   output logic [1:0]            rsp_event_channel,
   output logic [31:0]           rsp_count_value,
   output logic                  rsp_last_of_run
);
   import smpc_pkg::*;

   localparam int EW = 2 * CHANNELS;
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IW = CW + 1;
   localparam int PW = (CHANNELS > PIN_COUNT) ? CHANNELS : PIN_COUNT;

   logic [31:0] pulse_count_ff  [CHANNELS];
   logic [31:0] pulse_count_in  [CHANNELS];
   logic [15:0] since_sample_ff [CHANNELS];
   logic [15:0] since_sample_in [CHANNELS];
   logic [15:0] since_query_ff  [CHANNELS];
   logic [15:0] since_query_in  [CHANNELS];
   logic [CHANNELS-1:0] prev_level_ff, prev_level_in;
   logic [CHANNELS-1:0] init_rx_ff, init_rx_in;
   logic [CHANNELS-1:0] republish_ff, republish_in;
   logic first_pass_ff, first_pass_in;

   logic [EW-1:0]     pend_ff, pend_in;
   logic [RCNT_W-1:0] sent_ff, sent_in;
   logic [EW-1:0]     tick_events;
   logic [EW-1:0]     low_bit, pend_rest, pend_left;
   logic [IW-1:0]     sel_idx;
   logic [CW-1:0]     sel_ch;
   logic              out_free, emit, emit_last;
   logic              is_tick, is_init;
   logic [PW-1:0]     pins_w;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [1:0]  rsp_channel_ff;
   logic [31:0] rsp_count_ff;
   logic        rsp_last_ff;

   assign pins_w  = PW'(q_item.pins);
   assign is_tick = q_pop && (q_item.kind == ITEM_TICK);
   assign is_init = q_pop && (q_item.kind == ITEM_INIT);

   // Per-channel tick and initial-count update.
   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      logic [15:0] sq_inc, ss_inc;
      logic        cur, prev_eff, rise, samp, want_req, trig, hit;

      assign sq_inc   = sat_inc(since_query_ff[g]);
      assign ss_inc   = sat_inc(since_sample_ff[g]);
      assign cur      = pins_w[g];
      assign want_req = !init_rx_ff[g] && (sq_inc > cfg.query_period) && q_item.link_up;
      assign samp     = first_pass_ff || (ss_inc > cfg.sample_period);
      assign prev_eff = first_pass_ff ? cur : prev_level_ff[g];
      assign rise     = samp && cur && !prev_eff;
      assign trig     = samp && init_rx_ff[g] && (rise || republish_ff[g]);
      assign hit      = is_init && ({30'd0, q_item.channel} == 32'(g)) && !init_rx_ff[g];

      assign tick_events[2*g]   = want_req;
      assign tick_events[2*g+1] = trig && q_item.link_up;

      assign pulse_count_in[g]  = is_tick ? pulse_count_ff[g] + 32'(rise) :
                                  hit     ? pulse_count_ff[g] + q_item.value :
                                            pulse_count_ff[g];
      assign since_sample_in[g] = is_tick ? (samp ? 16'd0 : ss_inc) : since_sample_ff[g];
      assign since_query_in[g]  = is_tick ? (want_req ? 16'd0 : sq_inc) : since_query_ff[g];
      assign prev_level_in[g]   = (is_tick && samp) ? cur : prev_level_ff[g];
      assign init_rx_in[g]      = hit || init_rx_ff[g];
      assign republish_in[g]    = is_tick ? (republish_ff[g] && !trig) :
                                  hit     ? (pulse_count_ff[g] != 32'd0) :
                                            republish_ff[g];
   end

   // Walk pending events lowest first: request then publish, channel by channel.
   always_comb begin
      low_bit   = pend_ff & (~pend_ff + EW'(1));
      pend_rest = pend_ff & ~low_bit;
      sel_idx   = '0;
      for (int b = 0; b < EW; b++) begin
         if (low_bit[b]) begin
            sel_idx = sel_idx | IW'(b);
         end
      end
      sel_ch    = sel_idx[IW-1:1];
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit      = out_free && (pend_ff != '0);
      emit_last = (pend_rest == '0) || (sent_ff == RCNT_W'(RESULT_LIMIT - 1));
      pend_left = emit ? (emit_last ? '0 : pend_rest) : pend_ff;
      q_pop     = q_valid && (pend_left == '0);
   end

   always_comb begin
      pend_in       = is_tick ? tick_events : pend_left;
      sent_in       = is_tick ? '0 : (emit ? sent_ff + 1'b1 : sent_ff);
      first_pass_in = is_tick ? 1'b0 : first_pass_ff;
      rsp_valid_in  = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pulse_count_ff[i]  <= '0;
            since_sample_ff[i] <= '0;
            since_query_ff[i]  <= '0;
         end
         prev_level_ff <= '0;
         init_rx_ff    <= '0;
         republish_ff  <= '0;
         first_pass_ff <= 1'b1;
         pend_ff       <= '0;
         sent_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            pulse_count_ff[i]  <= pulse_count_in[i];
            since_sample_ff[i] <= since_sample_in[i];
            since_query_ff[i]  <= since_query_in[i];
         end
         prev_level_ff <= prev_level_in;
         init_rx_ff    <= init_rx_in;
         republish_ff  <= republish_in;
         first_pass_ff <= first_pass_in;
         pend_ff       <= pend_in;
         sent_ff       <= sent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= sel_idx[0];
         rsp_channel_ff <= 2'(sel_ch);
         rsp_count_ff   <= (sel_idx[0] == EV_PUBLISH) ? pulse_count_ff[sel_ch] : 32'd0;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_event_channel = rsp_channel_ff;
   assign rsp_count_value   = rsp_count_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   `SMPC_ASSERT_NEXT(a_no_invented_events, clock, reset, (pend_ff == '0) && !q_valid, pend_ff == '0)
   `SMPC_ASSERT_NEXT(a_last_drains, clock, reset, emit && emit_last && !is_tick, pend_ff == '0)
   `SMPC_ASSERT_NEXT(a_first_pass_once, clock, reset, is_tick, !first_pass_ff)
   `SMPC_ASSERT_NOW(a_pop_only_when_drained, clock, reset, q_pop && (pend_ff != '0), emit)

endmodule

>>> tb/sv/sampled_multichannel_pulse_counter_test.sv
`timescale 1ns / 1ps

module sampled_multichannel_pulse_counter_test;
   import smpc_pkg::*;

   localparam int CHANNELS     = 4;
   localparam int DRAIN_CYCLES = 12;       // tick latency plus queued initial counts
   localparam int HOLD_OFF     = 80;       // long receiver stall, fills the queue
   localparam int TIMEOUT_NS   = 2_000_000;

   // One item on the request channel.
   typedef struct packed {
      logic        opcode;
      logic [3:0]  pins;
      logic        link;
      logic [1:0]  channel;
      logic [31:0] init_value;
   } meter_item_t;

   // One event on the result channel.
   typedef struct packed {
      logic        kind;
      logic [1:0]  channel;
      logic [31:0] count;
      logic        last;
   } meter_event_t;

   // Tracks the meter state and holds the events each tick must produce.
   class meter_scoreboard;
      logic [15:0]  sample_period;
      logic [15:0]  query_period;
      logic [31:0]  pulse_count [CHANNELS];
      logic         level_held [CHANNELS];
      logic         have_initial [CHANNELS];
      logic         republish_armed [CHANNELS];
      logic [15:0]  since_sample [CHANNELS];
      logic [15:0]  since_query [CHANNELS];
      logic         first_tick;
      meter_event_t expected_events [$];
      int           mismatches;
      int           events_checked;
      int           requests_checked;
      int           publishes_checked;
      int           ticks_noted;
      int           inits_noted;

      function new();
         sample_period = SAMPLE_PERIOD_RESET;
         query_period  = QUERY_PERIOD_RESET;
         first_tick    = 1'b1;
         for (int i = 0; i < CHANNELS; i++) begin
            pulse_count[i]     = '0;
            level_held[i]      = 1'b0;
            have_initial[i]    = 1'b0;
            republish_armed[i] = 1'b0;
            since_sample[i]    = '0;
            since_query[i]     = '0;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
      endtask

      // Advance the meter by one accepted item and queue its events.
      function void note_item(meter_item_t it);
         meter_event_t burst [$];
         meter_event_t ev;
         logic         cur;
         logic         rising;
         if (it.opcode == OP_INIT) begin
            inits_noted++;
            if (!have_initial[it.channel]) begin
               republish_armed[it.channel] = (pulse_count[it.channel] != 32'd0);
               pulse_count[it.channel] += it.init_value;
               have_initial[it.channel] = 1'b1;
            end
            return;
         end
         ticks_noted++;
         for (int i = 0; i < CHANNELS; i++) begin
            if (since_sample[i] != 16'hFFFF) since_sample[i] += 16'd1;
            if (since_query[i] != 16'hFFFF) since_query[i] += 16'd1;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (!have_initial[i] && since_query[i] > query_period && it.link) begin
               ev = '{kind: EV_REQUEST, channel: 2'(i), count: 32'd0, last: 1'b0};
               burst.push_back(ev);
               since_query[i] = '0;
            end
            if (first_tick || since_sample[i] > sample_period) begin
               cur = it.pins[i];
               rising = 1'b0;
               since_sample[i] = '0;
               if (first_tick) level_held[i] = cur;
               if (cur != level_held[i]) begin
                  level_held[i] = cur;
                  rising = cur;
               end
               if (rising) pulse_count[i] += 32'd1;
               if (have_initial[i] && (rising || republish_armed[i])) begin
                  republish_armed[i] = 1'b0;
                  if (it.link) begin
                     ev = '{kind: EV_PUBLISH, channel: 2'(i), count: pulse_count[i],
                            last: 1'b0};
                     burst.push_back(ev);
                  end
               end
            end
         end
         first_tick = 1'b0;
         while (burst.size() > RESULT_LIMIT) void'(burst.pop_back());
         if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[k]) expected_events.push_back(burst[k]);
      endfunction

      // Compare one accepted event with the oldest expectation.
      task check_event(meter_event_t got);
         meter_event_t want;
         events_checked++;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d channel %0d count %08h",
                                      got.kind, got.channel, got.count));
            return;
         end
         want = expected_events.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d", got.kind, want.kind));
         if (got.channel !== want.channel)
            report_mismatch($sformatf("event_channel %0d, expected %0d",
                                      got.channel, want.channel));
         if (got.count !== want.count)
            report_mismatch($sformatf("count_value %08h, expected %08h",
                                      got.count, want.count));
         if (got.last !== want.last)
            report_mismatch($sformatf("last_of_run %0d, expected %0d", got.last, want.last));
         if (want.kind == EV_REQUEST) requests_checked++;
         else publishes_checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_TICK;
   logic [3:0]  req_pin_levels = '0;
   logic        req_link_up = 1'b0;
   logic [1:0]  req_channel = '0;
   logic [31:0] req_initial_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_kind;
   logic [1:0]  rsp_event_channel;
   logic [31:0] rsp_count_value;
   logic        rsp_last_of_run;
   logic        csr_write = 1'b0;
   logic        csr_index = REG_SAMPLE_PERIOD;
   logic [15:0] csr_data = '0;

   // Idle mix of the current phase, in percent, and a pending long stall.
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_off_left = 0;

   meter_scoreboard board = new();

   sampled_multichannel_pulse_counter #(.CHANNELS(CHANNELS)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: drop the stall at random, or hold it through a counted
   // stretch when the stimulus asks for one.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Monitor: sample at the falling edge, where valid and stall are settled
   // for the coming rising edge, and check every event that will be taken.
   initial begin
      meter_event_t seen;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen = '{kind: rsp_event_kind, channel: rsp_event_channel,
                     count: rsp_count_value, last: rsp_last_of_run};
            board.check_event(seen);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("sampled_multichannel_pulse_counter_test: FAIL");
      $finish;
   end

   function automatic meter_item_t make_item(logic op, logic [3:0] pins, logic link,
                                             logic [1:0] ch, logic [31:0] value);
      meter_item_t it;
      it = '{opcode: op, pins: pins, link: link, channel: ch, init_value: value};
      return it;
   endfunction

   // Offer one item, hold it while stalled, and note it once taken.
   // Called and returning at a rising edge.
   task automatic send_item(meter_item_t it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= it.opcode;
      req_pin_levels    <= it.pins;
      req_link_up       <= it.link;
      req_channel       <= it.channel;
      req_initial_value <= it.init_value;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      board.note_item(it);
   endtask

   // Stop offering, then wait for every expected event and the block's tail.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both periods on back-to-back edges; only while the block is idle.
   task automatic write_periods(logic [15:0] sample_ms, logic [15:0] query_ms);
      csr_write <= 1'b1;
      csr_index <= REG_SAMPLE_PERIOD;
      csr_data  <= sample_ms;
      @(posedge clock);
      csr_index <= REG_QUERY_PERIOD;
      csr_data  <= query_ms;
      @(posedge clock);
      csr_write <= 1'b0;
      board.sample_period = sample_ms;
      board.query_period  = query_ms;
   endtask

   // Random pulse trains with occasional initial counts. Ticks set the length;
   // pause_at drains the block once mid-phase (negative: never).
   task automatic run_random_phase(int ticks, int sender_idle, int receiver_stall,
                                   int pause_at);
      meter_item_t it;
      int          sent;
      sent = 0;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      while (sent < ticks) begin
         if (sent == pause_at) wait_drained();
         it.opcode  = ($urandom_range(99) < 10) ? OP_INIT : OP_TICK;
         it.pins    = 4'($urandom_range(15));
         it.link    = ($urandom_range(9) != 0);
         it.channel = 2'($urandom_range(3));
         case ($urandom_range(3))
            0: it.init_value = 32'd0;
            1: it.init_value = 32'hFFFF_FFFF;
            default: it.init_value = $urandom();
         endcase
         if (it.opcode == OP_TICK) sent++;
         send_item(it);
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset periods: the first tick loads the levels, nothing is sampled after.
      send_item(make_item(OP_TICK, 4'hF, 1'b1, 2'd0, 32'd0));
      send_item(make_item(OP_INIT, 4'h0, 1'b0, 2'd0, 32'hFFFF_FFFF));
      send_item(make_item(OP_TICK, 4'h0, 1'b1, 2'd3, 32'd0));
      wait_drained();

      // Periods one below the 16-bit maximum: timers stay below them.
      write_periods(16'd65534, 16'd65534);
      send_item(make_item(OP_TICK, 4'h5, 1'b1, 2'd1, 32'hA5A5_5A5A));
      wait_drained();

      // Zero periods: sample and query on every tick.
      write_periods(16'd0, 16'd0);
      // Falling pins only, requests for the channels still waiting.
      send_item(make_item(OP_TICK, 4'h0, 1'b1, 2'd2, 32'd0));
      // Edges everywhere; channel 0 wraps past all ones to zero.
      send_item(make_item(OP_TICK, 4'hF, 1'b1, 2'd0, 32'd0));
      // Initial count onto a nonzero count arms a republish; a repeat is ignored.
      send_item(make_item(OP_INIT, 4'hF, 1'b1, 2'd1, 32'h1234_5678));
      send_item(make_item(OP_INIT, 4'h0, 1'b0, 2'd1, 32'd0));
      // Link down: the republish is dropped, request timers keep running.
      send_item(make_item(OP_TICK, 4'hF, 1'b0, 2'd3, 32'hFFFF_FFFF));
      send_item(make_item(OP_INIT, 4'hA, 1'b1, 2'd2, 32'd0));
      send_item(make_item(OP_TICK, 4'hE, 1'b1, 2'd1, 32'd0));
      send_item(make_item(OP_TICK, 4'h1, 1'b1, 2'd0, 32'd0));
      send_item(make_item(OP_TICK, 4'hF, 1'b1, 2'd2, 32'd0));
      send_item(make_item(OP_TICK, 4'hF, 1'b1, 2'd3, 32'd0));
      send_item(make_item(OP_TICK, 4'h0, 1'b0, 2'd0, 32'd0));
      // Edges with the link down: counts move, nothing is published.
      send_item(make_item(OP_TICK, 4'hF, 1'b0, 2'd1, 32'd0));
      send_item(make_item(OP_TICK, 4'h6, 1'b1, 2'd0, 32'd0));
      wait_drained();

      // No idling; open with a long receiver stall so the input backs up.
      write_periods(16'd0, 16'd1);
      hold_off_left = HOLD_OFF;
      run_random_phase(22, 0, 0, -1);

      // Sender idle most of the time; pause once for a full drain.
      write_periods(16'd1, 16'd2);
      run_random_phase(22, 57, 0, 12);

      // Receiver stalling most of the time.
      write_periods(16'd2, 16'd0);
      run_random_phase(22, 0, 57, -1);

      // Both sides idle now and then.
      write_periods(16'd0, 16'd5);
      run_random_phase(22, 22, 22, -1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      foreach (board.expected_events[k]) begin
         board.report_mismatch($sformatf("missing event kind %0d channel %0d count %08h",
                                         board.expected_events[k].kind,
                                         board.expected_events[k].channel,
                                         board.expected_events[k].count));
      end

      $display("covered %0d ticks and %0d initial counts over seven period settings",
               board.ticks_noted, board.inits_noted);
      $display("checked %0d events (%0d requests, %0d publishes), %0d mismatches",
               board.events_checked, board.requests_checked, board.publishes_checked,
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("sampled_multichannel_pulse_counter_test: PASS");
      end else begin
         $display("sampled_multichannel_pulse_counter_test: FAIL");
      end
      $finish;
   end

endmodule
